>>> sv/psvp_pkg.sv
// Package for the polyphonic sine voice pool: codes, widths and defaults.
// No dependencies.
package psvp_pkg;
	localparam int NumVoicesDef = 16;
	localparam int SineBitsDef = 10;
	localparam logic [23:0] AttackReset = 24'd437;
	localparam logic [23:0] ReleaseReset = 24'd140;
	localparam logic [23:0] EnvFull = 24'hFFFFFF;

	typedef enum logic [1:0] {
		OP_NOTE_ON = 2'd0,
		OP_NOTE_OFF = 2'd1,
		OP_ALL_OFF = 2'd2,
		OP_TICK = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_ATTACK = 2'd1,
		MODE_SUSTAIN = 2'd2,
		MODE_RELEASE = 2'd3
	} mode_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_NOTE,
		ST_ENV,
		ST_SIN1,
		ST_SIN2,
		ST_SIN3,
		ST_SIN4,
		ST_MUL1,
		ST_MUL2,
		ST_ACC,
		ST_OUT1,
		ST_OUT2
	} state_t;

	localparam logic [2:0] RegAttack = 3'd0;
	localparam logic [2:0] RegRelease = 3'd4;
endpackage

>>> sv/polyphonic_sine_voice_pool_top.sv
// Top level of the polyphonic sine voice pool: sequencer, voice store and one shared multiplier.
// Depends on psvp_pkg.
//
// Usage:
// Input items arrive on s_axis (tdata: opcode, source_id, pitch_step, amplitude). A tick
// item gives one result on m_axis (tdata: sample, active_voices); other opcodes give none.
// Registers attack_step (0x0) and release_step (0x4) are written over the APB port.
// Each item visits the voices one at a time through one 32x32 multiplier. A note-on or
// note-off scans all voices for the owner and a free slot, then does the update and
// returns to idle; all-off scans and sets each active voice to release. A tick steps each
// voice through the envelope update, the sine steps, the level and envelope multiplies and
// the accumulate, then takes the output steps; the next transfer follows once it is idle.
// s_axis_tready is high only while the sequencer is idle. A result waits in the output
// register while the receiver stalls; the next item is still taken, and a following tick
// holds in its last step until the register frees, which then blocks further input.
// Reset clears all voices to idle and the registers to their defaults; no clearing pass.
module polyphonic_sine_voice_pool_top #(
	parameter int NUM_VOICES = psvp_pkg::NumVoicesDef,
	parameter int SINE_TABLE_BITS = psvp_pkg::SineBitsDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// opcode[1:0], source_id[9:2], pitch_step[33:10], amplitude[50:34], zero fill
	input  logic [55:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// sample[15:0], active_voices[20:16], zero fill
	output logic [23:0] m_axis_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam int VW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
	localparam int CW = $clog2(NUM_VOICES + 1);

	logic [23:0] attack_q, release_q;
	logic [NUM_VOICES-1:0] used_q;
	logic [7:0]  owner_q [NUM_VOICES];
	logic [23:0] phase_q [NUM_VOICES];
	logic [23:0] step_q [NUM_VOICES];
	logic [16:0] level_q [NUM_VOICES];
	logic [23:0] env_q [NUM_VOICES];
	psvp_pkg::mode_t mode_q [NUM_VOICES];

	psvp_pkg::state_t state_q, state_d;
	logic [VW-1:0] idx_q;
	logic [1:0]  op_q;
	logic [7:0]  src_q;
	logic [23:0] pstep_q;
	logic [16:0] lvl_q;
	logic        found_q, have_free_q, have_min_q;
	logic [VW-1:0] found_idx_q, free_idx_q, min_idx_q;
	logic [23:0] min_env_q;
	logic [31:0] ma_q, mb_q;
	logic [63:0] prod;
	logic [31:0] z_q, z2_q, m_q;
	logic        neg_q;
	logic signed [36:0] mix_q;
	logic [CW-1:0] count_q;
	logic [15:0] sample_q;
	logic [4:0]  act_q;
	logic        out_valid_q;
	logic        out_load;
	logic        last_voice;

	assign pready = 1'b1;
	assign prdata = (paddr == psvp_pkg::RegAttack) ? {8'd0, attack_q} :
		(paddr == psvp_pkg::RegRelease) ? {8'd0, release_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_q <= psvp_pkg::AttackReset;
			release_q <= psvp_pkg::ReleaseReset;
		end else if (psel && penable && pwrite) begin
			if (paddr == psvp_pkg::RegAttack) attack_q <= pwdata[23:0];
			if (paddr == psvp_pkg::RegRelease) release_q <= pwdata[23:0];
		end
	end

	assign s_axis_tready = (state_q == psvp_pkg::ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {3'd0, act_q, sample_q};
	assign last_voice = (idx_q == VW'(NUM_VOICES - 1));
	// load the output register once it is empty or being read out
	assign out_load = (state_q == psvp_pkg::ST_OUT2) && (!out_valid_q || m_axis_tready);

	// one shared multiplier
	assign prod = 64'(ma_q) * 64'(mb_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			psvp_pkg::ST_IDLE:
				if (s_axis_tvalid && s_axis_tready) begin
					if (s_axis_tdata[1:0] == psvp_pkg::OP_TICK) state_d = psvp_pkg::ST_ENV;
					else state_d = psvp_pkg::ST_SCAN;
				end
			psvp_pkg::ST_SCAN:
				if (last_voice) begin
					if (op_q == psvp_pkg::OP_ALL_OFF) state_d = psvp_pkg::ST_IDLE;
					else state_d = psvp_pkg::ST_NOTE;
				end
			psvp_pkg::ST_NOTE: state_d = psvp_pkg::ST_IDLE;
			psvp_pkg::ST_ENV: state_d = psvp_pkg::ST_SIN1;
			psvp_pkg::ST_SIN1: state_d = psvp_pkg::ST_SIN2;
			psvp_pkg::ST_SIN2: state_d = psvp_pkg::ST_SIN3;
			psvp_pkg::ST_SIN3: state_d = psvp_pkg::ST_SIN4;
			psvp_pkg::ST_SIN4: state_d = psvp_pkg::ST_MUL1;
			psvp_pkg::ST_MUL1: state_d = psvp_pkg::ST_MUL2;
			psvp_pkg::ST_MUL2: state_d = psvp_pkg::ST_ACC;
			psvp_pkg::ST_ACC: state_d = last_voice ? psvp_pkg::ST_OUT1 : psvp_pkg::ST_ENV;
			psvp_pkg::ST_OUT1: state_d = psvp_pkg::ST_OUT2;
			psvp_pkg::ST_OUT2: state_d = out_load ? psvp_pkg::ST_IDLE : psvp_pkg::ST_OUT2;
			default: state_d = psvp_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= psvp_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			used_q <= '0;
			idx_q <= '0;
			for (int i = 0; i < NUM_VOICES; i++) mode_q[i] <= psvp_pkg::MODE_IDLE;
		end else begin
			state_q <= state_d;
			if (out_load) out_valid_q <= 1'b1;
			else if (m_axis_tvalid && m_axis_tready) out_valid_q <= 1'b0;
			unique case (state_q)
				psvp_pkg::ST_IDLE: idx_q <= '0;
				psvp_pkg::ST_SCAN: begin
					if (op_q == psvp_pkg::OP_ALL_OFF) begin
						if (used_q[idx_q] && mode_q[idx_q] != psvp_pkg::MODE_IDLE)
							mode_q[idx_q] <= psvp_pkg::MODE_RELEASE;
					end
					idx_q <= last_voice ? '0 : idx_q + VW'(1);
				end
				psvp_pkg::ST_NOTE: begin
					if (op_q == psvp_pkg::OP_NOTE_ON) begin
						used_q[found_q ? found_idx_q : (have_free_q ? free_idx_q : min_idx_q)]
							<= 1'b1;
						mode_q[found_q ? found_idx_q : (have_free_q ? free_idx_q : min_idx_q)]
							<= psvp_pkg::MODE_ATTACK;
					end else if (found_q && mode_q[found_idx_q] != psvp_pkg::MODE_IDLE) begin
						mode_q[found_idx_q] <= psvp_pkg::MODE_RELEASE;
					end
				end
				psvp_pkg::ST_ENV: begin
					if (used_q[idx_q]) begin
						if (mode_q[idx_q] == psvp_pkg::MODE_ATTACK) begin
							if (env_sum >= {1'b0, psvp_pkg::EnvFull})
								mode_q[idx_q] <= psvp_pkg::MODE_SUSTAIN;
						end else if (mode_q[idx_q] == psvp_pkg::MODE_RELEASE &&
								env_q[idx_q] <= release_q) begin
							mode_q[idx_q] <= psvp_pkg::MODE_IDLE;
							used_q[idx_q] <= 1'b0;
						end
					end
				end
				psvp_pkg::ST_ACC: idx_q <= last_voice ? '0 : idx_q + VW'(1);
				default: ;
			endcase
		end
	end

	// datapath and voice payload
	logic [22:0] r_fold;
	logic [23:0] ph_trunc;
	logic [24:0] env_sum;
	logic [30:0] mix_mag;
	always_comb begin
		ph_trunc = phase_q[idx_q] & ~24'((1 << (24 - SINE_TABLE_BITS)) - 1);
		r_fold = (ph_trunc[22:0] >= 23'h400000) ? 23'(24'h800000 - {1'b0, ph_trunc[22:0]})
			: ph_trunc[22:0];
		env_sum = {1'b0, env_q[idx_q]} + {1'b0, attack_q};
		mix_mag = (mix_q > 37'sd1073741824) ? 31'h40000000 :
			(mix_q < -37'sd1073741824) ? 31'h40000000 :
			(mix_q < 0) ? 31'(-mix_q) : 31'(mix_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_VOICES; i++) begin
				owner_q[i] <= '0;
				phase_q[i] <= '0;
				step_q[i] <= '0;
				level_q[i] <= '0;
				env_q[i] <= '0;
			end
			op_q <= '0;
			src_q <= '0;
			pstep_q <= '0;
			lvl_q <= '0;
			found_q <= 1'b0;
			have_free_q <= 1'b0;
			have_min_q <= 1'b0;
			found_idx_q <= '0;
			free_idx_q <= '0;
			min_idx_q <= '0;
			min_env_q <= '0;
			ma_q <= '0;
			mb_q <= '0;
			z_q <= '0;
			z2_q <= '0;
			m_q <= '0;
			neg_q <= 1'b0;
			mix_q <= '0;
			count_q <= '0;
			sample_q <= '0;
			act_q <= '0;
		end else begin
			unique case (state_q)
				psvp_pkg::ST_IDLE: begin
					op_q <= s_axis_tdata[1:0];
					src_q <= s_axis_tdata[9:2];
					pstep_q <= s_axis_tdata[33:10];
					lvl_q <= s_axis_tdata[50] ? 17'd0 :
						(s_axis_tdata[49:34] > 16'd32768) ? 17'd32768
						: {1'b0, s_axis_tdata[49:34]};
					found_q <= 1'b0;
					have_free_q <= 1'b0;
					have_min_q <= 1'b0;
					found_idx_q <= '0;
					free_idx_q <= '0;
					min_idx_q <= '0;
					min_env_q <= '0;
					mix_q <= '0;
					count_q <= '0;
				end
				psvp_pkg::ST_SCAN: begin
					if (!found_q && used_q[idx_q] && owner_q[idx_q] == src_q) begin
						found_q <= 1'b1;
						found_idx_q <= idx_q;
					end
					if (!have_free_q && !used_q[idx_q]) begin
						have_free_q <= 1'b1;
						free_idx_q <= idx_q;
					end
					if (used_q[idx_q] && (!have_min_q || env_q[idx_q] < min_env_q)) begin
						have_min_q <= 1'b1;
						min_env_q <= env_q[idx_q];
						min_idx_q <= idx_q;
					end
				end
				psvp_pkg::ST_NOTE:
					if (op_q == psvp_pkg::OP_NOTE_ON) begin
						if (!found_q) phase_q[have_free_q ? free_idx_q : min_idx_q] <= '0;
						owner_q[found_q ? found_idx_q : (have_free_q ? free_idx_q : min_idx_q)]
							<= src_q;
						step_q[found_q ? found_idx_q : (have_free_q ? free_idx_q : min_idx_q)]
							<= pstep_q;
						level_q[found_q ? found_idx_q : (have_free_q ? free_idx_q : min_idx_q)]
							<= lvl_q;
					end
				psvp_pkg::ST_ENV: begin
					if (used_q[idx_q]) begin
						if (mode_q[idx_q] == psvp_pkg::MODE_ATTACK)
							env_q[idx_q] <= (env_sum >= {1'b0, psvp_pkg::EnvFull}) ?
								psvp_pkg::EnvFull : env_sum[23:0];
						else if (mode_q[idx_q] == psvp_pkg::MODE_RELEASE)
							env_q[idx_q] <= (env_q[idx_q] <= release_q) ? 24'd0
								: env_q[idx_q] - release_q;
					end
					neg_q <= ph_trunc[23];
					z_q <= 32'(r_fold >> 7);
					ma_q <= 32'(r_fold >> 7);
					mb_q <= 32'(r_fold >> 7);
				end
				psvp_pkg::ST_SIN1: begin
					z2_q <= 32'(prod >> 15);
					ma_q <= 32'(prod >> 15);
					mb_q <= 32'd4640;
				end
				psvp_pkg::ST_SIN2: begin
					ma_q <= z2_q;
					mb_q <= 32'd42047 - 32'(prod >> 15);
				end
				psvp_pkg::ST_SIN3: begin
					ma_q <= z_q;
					mb_q <= 32'd102944 - 32'(prod >> 15);
				end
				psvp_pkg::ST_SIN4: begin
					ma_q <= (prod[47:16] > 32'd32767) ? 32'd32767 : prod[47:16];
					mb_q <= {15'd0, level_q[idx_q]};
				end
				psvp_pkg::ST_MUL1: begin
					ma_q <= prod[31:0];
					mb_q <= {8'd0, env_q[idx_q]};
				end
				psvp_pkg::ST_MUL2: m_q <= prod[55:24];
				psvp_pkg::ST_ACC:
					if (used_q[idx_q]) begin
						mix_q <= neg_q ? mix_q - 37'($signed({1'b0, m_q})) :
							mix_q + 37'($signed({1'b0, m_q}));
						phase_q[idx_q] <= phase_q[idx_q] + step_q[idx_q];
						if (mode_q[idx_q] != psvp_pkg::MODE_IDLE) count_q <= count_q + CW'(1);
					end
				psvp_pkg::ST_OUT1: begin
					ma_q <= {1'b0, mix_mag};
					mb_q <= 32'd32767;
				end
				psvp_pkg::ST_OUT2:
					if (out_load) begin
						sample_q <= (mix_q < 0) ? 16'(-{1'b0, prod[45:30]}) : prod[45:30];
						act_q <= (32'(count_q) > 32'd31) ? 5'd31 : 5'(count_q);
					end
				default: ;
			endcase
		end
	end
endmodule

>>> sv/psvp_checker.sv
// Port checker for the polyphonic sine voice pool, bound to the top level.
// Depends on polyphonic_sine_voice_pool_top.
module psvp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata,
	input logic        pready
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped under stall");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken twice in a row");
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({s_axis_tready, m_axis_tvalid}))
		else $error("handshake unknown");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[23:21] == 3'd0)
		else $error("fill bits not zero");
	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");
endmodule

bind polyphonic_sine_voice_pool_top psvp_checker u_psvp_checker (
	.clk(clk), .arst_n(arst_n), .s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata), .pready(pready)
);

>>> test/tb_polyphonic_sine_voice_pool_top.sv
// Testbench for the polyphonic sine voice pool: a directed table, then random phases
// under several register settings and idling patterns, checked against a local predictor.
// Depends on psvp_pkg and polyphonic_sine_voice_pool_top.
`timescale 1ns / 100ps

module tb_polyphonic_sine_voice_pool_top;
	import psvp_pkg::*;

	localparam int Voices = 16;
	localparam int SineBits = 10;
	localparam int CycleLimit = 1500000;
	localparam int DrainCycles = 300;

	typedef struct packed {
		logic [15:0] sample;
		logic [4:0]  active;
	} mix_out_t;

	typedef struct {
		opcode_t     op;
		logic [7:0]  src;
		logic [23:0] pitch;
		logic [16:0] amp;
		bit          typed;
		mix_out_t    want;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [55:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// predictor state
	logic [23:0] attack_rate, release_rate;
	bit          v_used [Voices];
	logic [7:0]  v_owner [Voices];
	logic [23:0] v_phase [Voices];
	logic [23:0] v_step [Voices];
	logic [16:0] v_level [Voices];
	logic [23:0] v_env [Voices];
	mode_t       v_mode [Voices];

	mix_out_t    pending_mix [$];
	int          errors = 0;
	int          cycles = 0;
	int          ticks_seen = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	bit          long_hold = 1'b0;

	polyphonic_sine_voice_pool_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("timeout after %0d cycles", cycles);
			$display("status: fail");
			$finish;
		end
	end

	task automatic report(input string what);
		$display("mismatch: %s", what);
		errors++;
	endtask

	function automatic logic [15:0] sine_magnitude(input logic [23:0] ph, output bit neg);
		longint unsigned r, z, z2, t, s;
		logic [23:0] u;
		u = ph & ~((24'd1 << (24 - SineBits)) - 24'd1);
		neg = u[23];
		r = u[22:0];
		if (r >= 64'h400000) r = 64'h800000 - r;
		z = r >> 7;
		z2 = (z * z) >> 15;
		t = 42047 - ((z2 * 4640) >> 15);
		t = 102944 - ((z2 * t) >> 15);
		s = (z * t) >> 16;
		if (s > 32767) s = 32767;
		return s[15:0];
	endfunction

	function automatic int voice_of(input logic [7:0] src);
		for (int i = 0; i < Voices; i++)
			if (v_used[i] && v_owner[i] == src) return i;
		return -1;
	endfunction

	function automatic int slot_to_take();
		int best;
		best = 0;
		for (int i = 0; i < Voices; i++) begin
			if (!v_used[i]) return i;
			if (v_env[i] < v_env[best]) best = i;
		end
		return best;
	endfunction

	function automatic void clear_voices();
		for (int i = 0; i < Voices; i++) begin
			v_used[i] = 0; v_owner[i] = '0; v_phase[i] = '0; v_step[i] = '0;
			v_level[i] = '0; v_env[i] = '0; v_mode[i] = MODE_IDLE;
		end
	endfunction

	// advance the voice pool by one item; returns 1 when a sample is produced
	function automatic bit run_voices(input opcode_t op, input logic [7:0] src,
			input logic [23:0] pitch, input logic [16:0] amp, output mix_out_t res);
		int s, count;
		longint signed mix, lim;
		longint unsigned m, mag, smp;
		logic [31:0] e;
		bit neg;
		res = '0;
		case (op)
			OP_NOTE_ON: begin
				s = voice_of(src);
				if (s < 0) begin
					s = slot_to_take();
					v_phase[s] = '0;
				end
				v_level[s] = amp[16] ? 17'd0 : (amp > 17'd32768 ? 17'd32768 : amp);
				v_used[s] = 1; v_owner[s] = src; v_step[s] = pitch; v_mode[s] = MODE_ATTACK;
				return 0;
			end
			OP_NOTE_OFF: begin
				s = voice_of(src);
				if (s >= 0 && v_mode[s] != MODE_IDLE) v_mode[s] = MODE_RELEASE;
				return 0;
			end
			OP_ALL_OFF: begin
				for (int i = 0; i < Voices; i++)
					if (v_used[i] && v_mode[i] != MODE_IDLE) v_mode[i] = MODE_RELEASE;
				return 0;
			end
			default: begin
				mix = 0;
				lim = 64'sd1 << 30;
				for (int i = 0; i < Voices; i++) begin
					if (!v_used[i]) continue;
					if (v_mode[i] == MODE_ATTACK) begin
						e = v_env[i] + attack_rate;
						if (e >= EnvFull) begin
							e = EnvFull;
							v_mode[i] = MODE_SUSTAIN;
						end
						v_env[i] = e[23:0];
					end else if (v_mode[i] == MODE_RELEASE) begin
						if (v_env[i] <= release_rate) begin
							v_env[i] = '0; v_mode[i] = MODE_IDLE; v_used[i] = 0;
						end else begin
							v_env[i] = v_env[i] - release_rate;
						end
					end
					if (!v_used[i]) continue;
					m = sine_magnitude(v_phase[i], neg) * longint'(v_level[i]);
					m = (m * v_env[i]) >> 24;
					mix += neg ? -longint'(m) : longint'(m);
					v_phase[i] = v_phase[i] + v_step[i];
				end
				if (mix > lim) mix = lim;
				if (mix < -lim) mix = -lim;
				mag = mix < 0 ? -mix : mix;
				smp = (mag * 32767) >> 30;
				if (mix < 0) smp = -smp;
				count = 0;
				for (int i = 0; i < Voices; i++)
					if (v_used[i] && v_mode[i] != MODE_IDLE) count++;
				if (count > 31) count = 31;
				res.sample = smp[15:0];
				res.active = count[4:0];
				return 1;
			end
		endcase
	endfunction

	// result side: random stalls, long hold-off on request
	initial begin
		int held;
		forever begin
			@(posedge clk);
			if (long_hold) begin
				m_axis_tready <= 1'b0;
				held = 0;
				while (held < 3000) begin
					@(posedge clk);
					held++;
				end
				long_hold = 1'b0;
			end
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		mix_out_t want, got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.sample = m_axis_tdata[15:0];
			got.active = m_axis_tdata[20:16];
			ticks_seen++;
			if (pending_mix.size() == 0) begin
				report($sformatf("unexpected sample %h", got.sample));
			end else begin
				want = pending_mix.pop_front();
				if (got.sample !== want.sample)
					report($sformatf("sample %h, wanted %h", got.sample, want.sample));
				if (got.active !== want.active)
					report($sformatf("active %0d, wanted %0d", got.active, want.active));
			end
		end
	end

	task automatic send(input opcode_t op, input logic [7:0] src, input logic [23:0] pitch,
			input logic [16:0] amp, input bit typed, input mix_out_t want);
		mix_out_t res;
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {5'b0, amp, pitch, src, op};
		do @(posedge clk); while (!s_axis_tready);
		if (run_voices(op, src, pitch, amp, res)) pending_mix.push_back(typed ? want : res);
		gap = 0;
		while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending_mix.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] addr, input logic [23:0] value);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= {8'b0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (addr == RegAttack) attack_rate = value;
		else release_rate = value;
	endtask

	task automatic random_items(input int n);
		int pick;
		logic [7:0] src;
		logic [16:0] amp;
		for (int k = 0; k < n; k++) begin
			pick = $urandom_range(99);
			src = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(23));
			amp = ($urandom_range(3) == 0) ? 17'($urandom) : 17'($urandom_range(32768));
			if (pick < 50) send(OP_TICK, 8'($urandom), 24'($urandom), 17'($urandom), 0, '0);
			else if (pick < 78) send(OP_NOTE_ON, src, 24'($urandom), amp, 0, '0);
			else if (pick < 97) send(OP_NOTE_OFF, src, 24'($urandom), amp, 0, '0);
			else send(OP_ALL_OFF, src, 24'($urandom), amp, 0, '0);
		end
	endtask

	row_t table_rows [] = '{
		'{OP_TICK,     8'h00, 24'h000000, 17'h00000, 1, '{16'h0000, 5'd0}},
		'{OP_NOTE_ON,  8'h00, 24'h000000, 17'h08000, 0, '0},
		'{OP_TICK,     8'h00, 24'h000000, 17'h00000, 1, '{16'h0000, 5'd1}},
		'{OP_NOTE_ON,  8'hFF, 24'hFFFFFF, 17'h0FFFF, 0, '0},
		'{OP_NOTE_ON,  8'h80, 24'h400000, 17'h10000, 0, '0},
		'{OP_TICK,     8'h00, 24'h000000, 17'h00000, 0, '0},
		'{OP_NOTE_ON,  8'h00, 24'h200000, 17'h04000, 0, '0},
		'{OP_TICK,     8'hFF, 24'hFFFFFF, 17'h1FFFF, 0, '0},
		'{OP_NOTE_OFF, 8'h55, 24'h000000, 17'h00000, 0, '0},
		'{OP_NOTE_OFF, 8'hFF, 24'h000000, 17'h00000, 0, '0},
		'{OP_TICK,     8'h00, 24'h000000, 17'h00000, 0, '0},
		'{OP_TICK,     8'h00, 24'h000000, 17'h00000, 0, '0},
		'{OP_NOTE_ON,  8'hAA, 24'h123456, 17'h08001, 0, '0},
		'{OP_TICK,     8'h00, 24'h000000, 17'h00000, 0, '0},
		'{OP_ALL_OFF,  8'h00, 24'h000000, 17'h00000, 0, '0},
		'{OP_TICK,     8'h00, 24'h000000, 17'h00000, 0, '0},
		'{OP_NOTE_OFF, 8'h00, 24'h000000, 17'h00000, 0, '0},
		'{OP_TICK,     8'h00, 24'h000000, 17'h00000, 0, '0}
	};

	initial begin
		logic [23:0] attack_set [5];
		logic [23:0] release_set [5];
		int idle_set [5];
		int stall_set [5];
		attack_set = '{24'h100000, 24'hFFFFFF, 24'h000001, 24'h123456, 24'h200000};
		release_set = '{24'h080000, 24'hFFFFFF, 24'h000001, 24'h0A0000, 24'h100000};
		idle_set = '{0, 75, 0, 30, 0};
		stall_set = '{0, 0, 75, 30, 0};
		attack_rate = AttackReset;
		release_rate = ReleaseReset;
		clear_voices();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (table_rows[i])
			send(table_rows[i].op, table_rows[i].src, table_rows[i].pitch,
				table_rows[i].amp, table_rows[i].typed, table_rows[i].want);
		drain();

		for (int p = 0; p < 5; p++) begin
			write_reg(RegAttack, attack_set[p]);
			write_reg(RegRelease, release_set[p]);
			send_idle_pct = idle_set[p];
			recv_stall_pct = stall_set[p];
			// hold the result side off while items keep coming, so the input stalls
			if (p == 4) long_hold = 1'b1;
			random_items(p == 2 ? 100 : 350);
			drain();
			if (p == 2) begin
				// release to silence before the extreme steps take over
				write_reg(RegRelease, 24'hFFFFFF);
				send(OP_ALL_OFF, 8'h00, '0, '0, 0, '0);
				send(OP_TICK, 8'h00, '0, '0, 0, '0);
				random_items(250);
				drain();
			end
		end

		$display("run covered %0d samples over five register settings", ticks_seen);
		$display("idling mixes: none, sender, receiver, both, long receiver hold-off");
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d mismatches", errors);
			$display("status: fail");
		end
		$finish;
	end
endmodule

>>> files.f
sv/psvp_pkg.sv
sv/polyphonic_sine_voice_pool_top.sv
sv/psvp_checker.sv
test/tb_polyphonic_sine_voice_pool_top.sv
